>>> rtl/core/taylor_trig_unit_assert.svh
// assertion macros used by the taylor trig unit checker
`ifndef TAYLOR_TRIG_UNIT_ASSERT_SVH
`define TAYLOR_TRIG_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("taylor trig unit check failed");

// next-cycle implication, sampled on clk, off during reset
`define TT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("taylor trig unit check failed");

`endif

>>> rtl/core/tt_pkg.sv
// types and constants of the taylor trig unit
`timescale 1ns / 1ps
package tt_pkg;
	localparam int FRAC_BITS = 28;
	localparam int THETA_W   = 32;
	localparam int VAL_W     = 48;
	localparam int ANG_W     = THETA_W + 1;
	localparam int XM_W      = 32;
	localparam int X2_W      = 36;
	localparam int MAG_W     = 62;
	localparam int DIG_W     = 12;
	localparam int N_DIG     = X2_W / DIG_W;
	localparam int PP_W      = MAG_W + DIG_W;
	localparam int ACC_W     = MAG_W + X2_W;
	localparam int DVD_W     = 96;
	localparam int REM_W     = MAG_W + 1;
	localparam int K_W       = 8;
	localparam int KK_W      = 2 * K_W;
	localparam int CNT_W     = 7;
	localparam int SER_N     = ACC_W - FRAC_BITS;
	localparam int FIN_N     = MAG_W + FRAC_BITS;
	localparam int SUM_W     = 64;

	localparam logic [MAG_W-1:0] MAG_LIMIT = {2'b01, {(MAG_W-2){1'b0}}};
	localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh2000_0000_0000_0000;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;
	localparam logic signed [SUM_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - 64'sd1;
	localparam logic signed [ANG_W-1:0] HALF_PI = 33'sd421657428;
	localparam logic [K_W-1:0] K_FIRST = 8'd3;

	typedef enum logic [1:0] {
		KIND_SIN = 2'd0,
		KIND_COS = 2'd1,
		KIND_TAN = 2'd2,
		KIND_COT = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_SQ,
		ST_CHECK,
		ST_MUL,
		ST_DIVS,
		ST_DIVW,
		ST_NEXT,
		ST_SAVE,
		ST_FCHK,
		ST_FDIVW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       load;
		logic       init;
		logic       use_cos;
		logic       sq;
		logic       add;
		logic       set_nc;
		logic       mul_step;
		logic [1:0] dig;
		logic       div_term;
		logic       term_done;
		logic       save;
		logic       div_final;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  mag_gt_tol;
		logic  div_busy;
		logic  den_zero;
	} stat_t;
endpackage

>>> rtl/core/tt_dp.sv
// datapath of the taylor trig unit: series registers, multiplier, divider, result
`timescale 1ns / 1ps
module tt_dp
	import tt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_wdata,
	input  logic [1:0]              in_kind,
	input  logic signed [THETA_W-1:0] in_theta,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	output logic signed [VAL_W-1:0] value,
	output logic                    div_by_zero,
	output logic                    saturated,
	output logic                    not_converged
);
	logic [31:0]              tol_q;
	kind_t                    kind_q;
	logic signed [THETA_W-1:0] theta_q;
	logic [XM_W-1:0]          xm_q;
	logic                     neg_q;
	logic [X2_W-1:0]          x2_q;
	logic [MAG_W-1:0]         mag_q;
	logic signed [SUM_W-1:0]  sum_q, s_q, c_q;
	logic [K_W-1:0]           k_q;
	logic [ACC_W-1:0]         acc_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [REM_W-1:0]         rem_q;
	logic [MAG_W-1:0]         dvs_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     clip_q, nc_q;
	logic signed [VAL_W-1:0]  value_q;
	logic                     dz_q, sat_q, ncout_q;

	logic signed [ANG_W-1:0]  angle;
	logic [ANG_W-1:0]         angle_mag;
	logic [2*XM_W-1:0]        xsq;
	logic signed [SUM_W-1:0]  sum_raw, sum_clip;
	logic                     sum_over;
	logic [DIG_W-1:0]         digit;
	logic [PP_W-1:0]          pp;
	logic [KK_W-1:0]          kk;
	logic [REM_W-1:0]         rem_sh;
	logic                     rem_ge;
	logic                     q_over;
	logic [MAG_W-1:0]         q_clip;
	logic signed [SUM_W-1:0]  num, den;
	logic [MAG_W-1:0]         num_mag, den_mag;
	logic signed [SUM_W-1:0]  fin_v;
	logic                     fin_dz, fin_clip;

	// angle of the series being started, magnitude form
	always_comb begin
		angle = cmd.use_cos ? ($signed({theta_q[THETA_W-1], theta_q}) + HALF_PI)
			: $signed({theta_q[THETA_W-1], theta_q});
		angle_mag = angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
	end

	assign xsq = (2*XM_W)'(xm_q) * (2*XM_W)'(xm_q);

	always_comb begin
		sum_raw = neg_q ? (sum_q - $signed({2'b00, mag_q})) : (sum_q + $signed({2'b00, mag_q}));
		sum_over = (sum_raw > SUM_MAX) || (sum_raw < SUM_MIN);
		if (sum_raw > SUM_MAX) begin
			sum_clip = SUM_MAX;
		end else if (sum_raw < SUM_MIN) begin
			sum_clip = SUM_MIN;
		end else begin
			sum_clip = sum_raw;
		end
	end

	assign digit = x2_q[cmd.dig*DIG_W +: DIG_W];
	assign pp    = PP_W'(mag_q) * PP_W'(digit);
	assign kk    = KK_W'(k_q) * KK_W'(k_q - K_W'(1));

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q[REM_W-2:0], dvd_q[DVD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dvs_q};

	assign q_over = dvd_q > DVD_W'(MAG_LIMIT);
	assign q_clip = q_over ? MAG_LIMIT : dvd_q[MAG_W-1:0];

	always_comb begin
		num = (kind_q == KIND_TAN) ? s_q : c_q;
		den = (kind_q == KIND_TAN) ? c_q : s_q;
		num_mag = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
		den_mag = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
	end

	always_comb begin
		fin_dz   = 1'b0;
		fin_clip = clip_q;
		unique case (kind_q)
			KIND_SIN: fin_v = s_q;
			KIND_COS: fin_v = c_q;
			default: begin
				if (den == '0) begin
					fin_dz   = 1'b1;
					fin_clip = 1'b1;
					fin_v    = num[SUM_W-1] ? OUT_MIN : OUT_MAX;
				end else begin
					fin_clip = clip_q | q_over;
					fin_v    = (num[SUM_W-1] != den[SUM_W-1]) ? -$signed({2'b00, q_clip})
						: $signed({2'b00, q_clip});
				end
			end
		endcase
		if (fin_v > OUT_MAX) begin
			fin_v    = OUT_MAX;
			fin_clip = 1'b1;
		end else if (fin_v < OUT_MIN) begin
			fin_v    = OUT_MIN;
			fin_clip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= 32'd3;
			cnt_q   <= '0;
			clip_q  <= 1'b0;
			nc_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (cmd.load) begin
				clip_q <= 1'b0;
				nc_q   <= 1'b0;
			end else begin
				if (cmd.add && sum_over) begin
					clip_q <= 1'b1;
				end
				if (cmd.term_done && q_over) begin
					clip_q <= 1'b1;
				end
				if (cmd.set_nc) begin
					nc_q <= 1'b1;
				end
			end
			if (cmd.div_term) begin
				cnt_q <= CNT_W'(SER_N);
			end else if (cmd.div_final) begin
				cnt_q <= CNT_W'(FIN_N);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind_t'(in_kind);
			theta_q <= in_theta;
			s_q     <= '0;
			c_q     <= '0;
		end
		if (cmd.init) begin
			xm_q  <= angle_mag[XM_W-1:0];
			neg_q <= angle[ANG_W-1];
			mag_q <= MAG_W'(angle_mag[XM_W-1:0]);
			sum_q <= '0;
			k_q   <= K_FIRST;
		end
		if (cmd.sq) begin
			x2_q <= xsq[FRAC_BITS +: X2_W];
		end
		if (cmd.add) begin
			sum_q <= sum_clip;
			acc_q <= '0;
		end
		if (cmd.mul_step) begin
			acc_q <= (acc_q << DIG_W) + ACC_W'(pp);
		end
		if (cmd.div_term) begin
			dvd_q <= {acc_q[ACC_W-1:FRAC_BITS], {(DVD_W-SER_N){1'b0}}};
			dvs_q <= MAG_W'(kk);
			rem_q <= '0;
		end else if (cmd.div_final) begin
			dvd_q <= {num_mag, {(DVD_W-MAG_W){1'b0}}};
			dvs_q <= den_mag;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
		end
		if (cmd.term_done) begin
			mag_q <= q_clip;
			neg_q <= ~neg_q;
			k_q   <= k_q + K_W'(2);
		end
		if (cmd.save) begin
			if (cmd.use_cos) begin
				c_q <= sum_q;
			end else begin
				s_q <= sum_q;
			end
		end
		if (cmd.finish) begin
			value_q <= fin_v[VAL_W-1:0];
			dz_q    <= fin_dz;
			sat_q   <= fin_clip;
			ncout_q <= nc_q;
		end
	end

	assign stat.kind       = kind_q;
	assign stat.mag_gt_tol = mag_q > MAG_W'(tol_q);
	assign stat.div_busy   = cnt_q != '0;
	assign stat.den_zero   = den == '0;

	assign value         = value_q;
	assign div_by_zero   = dz_q;
	assign saturated     = sat_q;
	assign not_converged = ncout_q;
endmodule

>>> rtl/core/tt_ctrl.sv
// sequencer of the taylor trig unit
`timescale 1ns / 1ps
module tt_ctrl
	import tt_pkg::*;
#(
	parameter int MAX_TERMS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_kind,
	output logic       out_valid,
	input  logic       out_ready,
	output cmd_t       cmd,
	input  stat_t      stat
);
	localparam int N_W = $clog2(MAX_TERMS + 1);

	state_t         state_q, state_d;
	logic [N_W-1:0] n_q;
	logic [1:0]     dig_q;
	logic           cos_q;
	logic           out_valid_q;
	logic           in_acc, out_free, at_max;

	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign at_max   = n_q == N_W'(MAX_TERMS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_INIT;
			ST_INIT:  state_d = ST_SQ;
			ST_SQ:    state_d = ST_CHECK;
			ST_CHECK: begin
				if (!stat.mag_gt_tol || at_max) begin
					state_d = ST_SAVE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:   if (dig_q == 2'd0) state_d = ST_DIVS;
			ST_DIVS:  state_d = ST_DIVW;
			ST_DIVW:  if (!stat.div_busy) state_d = ST_NEXT;
			ST_NEXT:  state_d = ST_CHECK;
			ST_SAVE: begin
				priority if (!cos_q && stat.kind != KIND_SIN) begin
					state_d = ST_INIT;
				end else if (stat.kind == KIND_TAN || stat.kind == KIND_COT) begin
					state_d = ST_FCHK;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FCHK:  state_d = stat.den_zero ? ST_FIN : ST_FDIVW;
			ST_FDIVW: if (!stat.div_busy) state_d = ST_FIN;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.use_cos = cos_q;
		cmd.dig     = dig_q;
		unique case (state_q)
			ST_IDLE:  cmd.load = in_acc;
			ST_INIT:  cmd.init = 1'b1;
			ST_SQ:    cmd.sq = 1'b1;
			ST_CHECK: begin
				cmd.set_nc = stat.mag_gt_tol && at_max;
				cmd.add    = stat.mag_gt_tol && !at_max;
			end
			ST_MUL:   cmd.mul_step = 1'b1;
			ST_DIVS:  cmd.div_term = 1'b1;
			ST_NEXT:  cmd.term_done = 1'b1;
			ST_SAVE:  cmd.save = 1'b1;
			ST_FCHK:  cmd.div_final = !stat.den_zero;
			ST_FIN:   cmd.finish = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			dig_q       <= '0;
			cos_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cos_q <= in_kind == KIND_COS;
			end else if (state_q == ST_SAVE) begin
				cos_q <= 1'b1;
			end
			if (state_q == ST_INIT) begin
				n_q <= '0;
			end else if (state_q == ST_NEXT) begin
				n_q <= n_q + N_W'(1);
			end
			if (state_q == ST_CHECK) begin
				dig_q <= 2'(N_DIG - 1);
			end else if (state_q == ST_MUL) begin
				dig_q <= dig_q - 2'd1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
endmodule

>>> rtl/core/taylor_trig_unit.sv
// top level of the taylor trig unit: sin, cos, tan, cot by taylor series
//
// usage
//  - input beat on s_*: s_tuser carries the function select, s_tdata the
//    angle in radians, signed with 28 fraction bits
//  - result beat on m_*: m_tdata the value with 28 fraction bits, m_tuser
//    the flags div_by_zero, saturated, not_converged
//  - cfg_* writes the tolerance; write it only while no beat is in flight
//  - one beat is worked on at a time; s_tready is high only when idle
//  - a series term multiplies through the digits of x squared, then runs
//    the bit-serial divider
//  - sin and cos run one series, tan and cot run two plus a final
//    quotient through the same divider
//  - each series is capped at MAX_TERMS terms
//  - the result sits in an output register; the next beat may be taken
//    while it waits, and a finished beat holds until m_tready frees it
//  - reset clears the sequencer, drops m_tvalid and sets tolerance to 3
`timescale 1ns / 1ps
module taylor_trig_unit
	import tt_pkg::*;
#(
	parameter int MAX_TERMS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // theta[31:0]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // value[47:0]
	output logic [2:0]  m_tuser,   // div_by_zero, saturated, not_converged
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // tolerance[31:0]
);
	cmd_t  cmd;
	stat_t stat;
	logic signed [VAL_W-1:0] value;
	logic dz, sat, nc;

	// the tolerance register is always writable
	assign cfg_ready = 1'b1;

	tt_ctrl #(
		.MAX_TERMS(MAX_TERMS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	tt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_wdata    (cfg_data),
		.in_kind      (s_tuser),
		.in_theta     ($signed(s_tdata)),
		.cmd          (cmd),
		.stat         (stat),
		.value        (value),
		.div_by_zero  (dz),
		.saturated    (sat),
		.not_converged(nc)
	);

	// result beat payload
	assign m_tdata = value;
	assign m_tuser = {nc, sat, dz};
endmodule

>>> rtl/core/tt_checker.sv
// port-level checks of the taylor trig unit and their binding
`timescale 1ns / 1ps
`include "taylor_trig_unit_assert.svh"
module tt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [31:0] cfg_data
);
	// stalled result holds
	`TT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	// a zero divisor always counts as a clip
	`TT_ASSERT_IMPL(a_dz_sat, m_tvalid && m_tuser[0], m_tuser[1])
	// a zero divisor gives a rail value
	`TT_ASSERT_IMPL(a_dz_rail, m_tvalid && m_tuser[0],
		(m_tdata == 48'h7FFF_FFFF_FFFF) || (m_tdata == 48'h8000_0000_0000))
	// one beat at a time: busy right after taking one
	`TT_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready)
endmodule

bind taylor_trig_unit tt_checker u_tt_checker (.*);

>>> dv/tb_top.sv
// self-checking testbench for taylor_trig_unit: a predictor checks every result beat
`timescale 1ns / 1ps
module tb_top;
	import tt_pkg::*;

	localparam int TERM_CAP = 32;
	localparam logic [63:0] CLIP_MAG = 64'h2000_0000_0000_0000;
	localparam longint VAL_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint VAL_LO = -VAL_HI - 64'sd1;
	localparam longint QUARTER_TURN = 64'sd421657428;

	typedef struct {
		logic [47:0] value;
		bit          dz;
		bit          sat;
		bit          nc;
	} trig_result_t;

	// predicts trig results and checks the result beats against them
	class trig_scoreboard;
		trig_result_t pending_q[$];
		logic [31:0]  tol;
		bit           clip;
		int           errors;
		int           n_in;
		int           n_out;
		int           n_dz;
		int           n_sat;
		int           n_nc;

		function new();
			tol = 32'd3;
		endfunction

		// truncating divide, clipped to the internal magnitude limit
		function logic [63:0] div_clip(logic [127:0] num, logic [63:0] d);
			logic [127:0] q;
			q = num / {64'b0, d};
			if (q > {64'b0, CLIP_MAG}) begin
				clip = 1;
				return CLIP_MAG;
			end
			return q[63:0];
		endfunction

		function longint sine_sum(longint x, inout bit nc);
			logic [63:0]  xm;
			logic [63:0]  x2;
			logic [63:0]  mag;
			logic [127:0] prod;
			longint       sum;
			bit           neg;
			int           n;
			logic [63:0]  k;
			xm = (x < 0) ? -x : x;
			prod = ({64'b0, xm} * {64'b0, xm}) >> FRAC_BITS;
			x2 = div_clip(prod, 64'd1);
			mag = xm;
			neg = x < 0;
			sum = 0;
			n = 0;
			k = 3;
			while (mag > {32'b0, tol}) begin
				if (n >= TERM_CAP) begin
					nc = 1;
					break;
				end
				sum = neg ? sum - longint'(mag) : sum + longint'(mag);
				if (sum > longint'(CLIP_MAG)) begin
					sum = longint'(CLIP_MAG);
					clip = 1;
				end else if (sum < -longint'(CLIP_MAG)) begin
					sum = -longint'(CLIP_MAG);
					clip = 1;
				end
				prod = ({64'b0, mag} * {64'b0, x2}) >> FRAC_BITS;
				mag = div_clip(prod, k * (k - 1));
				neg = !neg;
				n++;
				k += 2;
			end
			return sum;
		endfunction

		// accepted input beat: work out its result
		function void note(kind_t kind, logic [31:0] theta);
			trig_result_t r;
			longint ang;
			longint s;
			longint c;
			longint v;
			longint num;
			longint den;
			logic [63:0] nm;
			logic [63:0] dm;
			logic [63:0] q;
			bit nc;
			bit dz;
			ang = longint'($signed(theta));
			clip = 0;
			nc = 0;
			dz = 0;
			s = 0;
			c = 0;
			if (kind != KIND_COS)
				s = sine_sum(ang, nc);
			if (kind != KIND_SIN)
				c = sine_sum(ang + QUARTER_TURN, nc);
			if (kind == KIND_SIN) begin
				v = s;
			end else if (kind == KIND_COS) begin
				v = c;
			end else begin
				num = (kind == KIND_TAN) ? s : c;
				den = (kind == KIND_TAN) ? c : s;
				if (den == 0) begin
					dz = 1;
					clip = 1;
					v = (num < 0) ? VAL_LO : VAL_HI;
				end else begin
					nm = (num < 0) ? -num : num;
					dm = (den < 0) ? -den : den;
					q = div_clip({36'b0, nm, 28'b0}, dm);
					v = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
				end
			end
			if (v > VAL_HI) begin
				v = VAL_HI;
				clip = 1;
			end else if (v < VAL_LO) begin
				v = VAL_LO;
				clip = 1;
			end
			r.value = v[47:0];
			r.dz = dz;
			r.sat = clip;
			r.nc = nc;
			pending_q.push_back(r);
			n_in++;
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("%0t ns: result %0d %s got %0h want %0h", $time, n_out, what, got, want);
		endtask

		// accepted result beat: compare with the oldest expectation
		task check(logic [47:0] value, logic [2:0] flags);
			trig_result_t r;
			if (pending_q.size() == 0) begin
				report("unexpected beat", value, 0);
				return;
			end
			r = pending_q.pop_front();
			if (value !== r.value)
				report("value", value, r.value);
			if (flags[0] !== r.dz)
				report("div_by_zero", flags[0], r.dz);
			if (flags[1] !== r.sat)
				report("saturated", flags[1], r.sat);
			if (flags[2] !== r.nc)
				report("not_converged", flags[2], r.nc);
			n_dz += r.dz;
			n_sat += r.sat;
			n_nc += r.nc;
			n_out++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // theta[31:0]
	logic [1:0]  s_tuser;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // value[47:0]
	logic [2:0]  m_tuser;   // div_by_zero, saturated, not_converged
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;  // tolerance[31:0]

	trig_scoreboard sb = new();

	int burst_left;
	bit hold_req;     // asks the receiver for one long stall

	taylor_trig_unit #(.MAX_TERMS(TERM_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// beat monitors on the rising edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note(kind_t'(s_tuser), s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata, m_tuser);
	end

	// receiver: stall pattern changes at random, plus one long hold on request
	initial begin
		int mode;
		int hold_cnt;
		m_tready = 0;
		mode = 0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_cnt == 0) begin
				hold_cnt = 20000;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 0;
			end else begin
				if ($urandom_range(0, 63) == 0)
					mode = $urandom_range(0, 2);
				case (mode)
				0: m_tready <= 1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// sender: bursts of random length with random gaps between them
	task send(kind_t kind, logic [31:0] theta);
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= theta;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// stop sending and wait until every result is back
	task drain();
		int guard;
		@(negedge clk);
		s_tvalid <= 0;
		burst_left = 0;
		guard = 0;
		while (sb.pending_q.size() != 0 && guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task write_tol(logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.tol = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// angle mix: full range, around one turn, tiny, near the cosine zero, range ends
	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 9))
		0, 1, 2: return $urandom;
		3, 4, 5: return 32'($signed($urandom_range(0, 1686629713)) - 843314856);
		6: return 32'($signed($urandom_range(0, 200)) - 100);
		7: return 32'(-QUARTER_TURN + $signed($urandom_range(0, 8)) - 4);
		8: return 32'(QUARTER_TURN + $signed($urandom_range(0, 8)) - 4);
		default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
			: 32'h8000_0000 + $urandom_range(0, 3);
		endcase
	endfunction

	task run_random(int count);
		repeat (count) send(kind_t'($urandom_range(0, 3)), rand_angle());
	endtask

	initial begin
		kind_t k;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = KIND_SIN;
		cfg_valid = 0;
		cfg_data = 0;
		hold_req = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: zero angle, cosine zero for tan/cot, range ends, tiny angles
		for (int i = 0; i < 4; i++) begin
			k = kind_t'(i);
			send(k, 32'd0);
			send(k, 32'h7FFF_FFFF);
			send(k, 32'h8000_0000);
		end
		send(KIND_TAN, 32'(-QUARTER_TURN));
		send(KIND_COT, 32'(-QUARTER_TURN));
		send(KIND_COS, 32'(-QUARTER_TURN));
		send(KIND_SIN, 32'd3);
		send(KIND_SIN, 32'd4);
		send(KIND_SIN, 32'hFFFF_FFFC);
		send(KIND_COT, 32'd1);
		send(KIND_TAN, 32'hFFFF_FFFF);
		drain();

		// reset tolerance with the long receiver hold in the middle
		run_random(300);
		hold_req = 1;
		run_random(400);
		drain();

		write_tol(32'd0);
		run_random(150);
		drain();

		write_tol(32'hFFFF_FFFF);
		run_random(200);
		drain();

		write_tol($urandom_range(0, 4095));
		run_random(400);
		drain();

		write_tol($urandom);
		run_random(150);
		drain();

		write_tol(32'd1 << 20);
		run_random(200);
		drain();

		$display("covered %0d angles over six tolerance settings, %0d results checked",
			sb.n_in, sb.n_out);
		$display("flag counts: div_by_zero %0d, saturated %0d, not_converged %0d",
			sb.n_dz, sb.n_sat, sb.n_nc);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d results never arrived", sb.pending_q.size());
			$display("Mismatches found");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#600000000;
		$display("timeout");
		$display("Mismatches found");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/tt_pkg.sv
rtl/core/tt_dp.sv
rtl/core/tt_ctrl.sv
rtl/core/taylor_trig_unit.sv
rtl/core/tt_checker.sv
dv/tb_top.sv
